@@ src/bgc_pkg.sv @@
package bgc_pkg;

    // Event codes reported once per poll
    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_SHORT      = 3'd1,
        EV_LONG       = 3'd2,
        EV_EXTRA      = 3'd3,
        EV_DOUBLE     = 3'd4,
        EV_RESET_HOLD = 3'd5
    } t_event;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;

    // Configuration register map: byte address = 4 * index
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_GUARD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_LONG    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_HOLD    = 3'd5;

    // Reset values of the timing windows, in ms
    localparam logic [CFG_W-1:0] RST_DEBOUNCE      = 16'd150;
    localparam logic [CFG_W-1:0] RST_LONG_PRESS    = 16'd2000;
    localparam logic [CFG_W-1:0] RST_RELEASE_GUARD = 16'd50;
    localparam logic [CFG_W-1:0] RST_DOUBLE_WINDOW = 16'd250;
    localparam logic [CFG_W-1:0] RST_EXTRA_LONG    = 16'd20000;
    localparam logic [CFG_W-1:0] RST_RESET_HOLD    = 16'd20000;

    // Timing windows as seen by the classifier core
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] release_guard_ms;
        logic [CFG_W-1:0] double_click_window_ms;
        logic [CFG_W-1:0] extra_long_ms;
        logic [CFG_W-1:0] reset_hold_ms;
    } t_cfg;

endpackage

@@ src/bgc_poll_if.sv @@
interface bgc_poll_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_ms;
    logic        button_level;

    modport source (output valid, output time_ms, output button_level, input ready);
    modport sink   (input valid, input time_ms, input button_level, output ready);
endinterface

@@ src/bgc_event_if.sv @@
interface bgc_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;

    modport source (output valid, output event_code, input ready);
    modport sink   (input valid, input event_code, output ready);
endinterface

@@ src/bgc_core.sv @@
module bgc_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bgc_pkg::t_cfg               i_cfg,
    input  logic                        i_step,
    input  logic [bgc_pkg::TIME_W-1:0]  i_time_ms,
    input  logic                        i_button_level,
    output bgc_pkg::t_event             o_event_code
);

    logic                       r_is_pressed;
    logic [bgc_pkg::TIME_W-1:0] r_last_event_time;
    logic [bgc_pkg::TIME_W-1:0] r_press_start;
    logic [bgc_pkg::TIME_W-1:0] r_window_start;
    logic                       r_awaiting_second;
    logic                       r_hold_reported;

    logic                       n_is_pressed;
    logic [bgc_pkg::TIME_W-1:0] n_last_event_time;
    logic [bgc_pkg::TIME_W-1:0] n_press_start;
    logic [bgc_pkg::TIME_W-1:0] n_window_start;
    logic                       n_awaiting_second;
    logic                       n_hold_reported;

    logic [bgc_pkg::TIME_W-1:0] since_last;
    logic [bgc_pkg::TIME_W-1:0] held;
    logic [bgc_pkg::TIME_W-1:0] since_window;
    bgc_pkg::t_event            event_code;

    // Wrapping elapsed times
    assign since_last   = i_time_ms - r_last_event_time;
    assign held         = i_time_ms - r_press_start;
    assign since_window = i_time_ms - n_window_start;

    // Classify one poll and work out the next state
    always_comb begin
        n_is_pressed      = r_is_pressed;
        n_last_event_time = r_last_event_time;
        n_press_start     = r_press_start;
        n_window_start    = r_window_start;
        n_awaiting_second = r_awaiting_second;
        n_hold_reported   = r_hold_reported;
        event_code        = bgc_pkg::EV_NONE;

        if (!i_button_level) begin
            // release, once the guard time has passed
            if (r_is_pressed && (since_last > {16'd0, i_cfg.release_guard_ms})) begin
                if (held > {16'd0, i_cfg.long_press_ms}) begin
                    event_code = (held < {16'd0, i_cfg.extra_long_ms}) ?
                                 bgc_pkg::EV_LONG : bgc_pkg::EV_EXTRA;
                end else if (r_awaiting_second) begin
                    event_code        = bgc_pkg::EV_DOUBLE;
                    n_awaiting_second = 1'b0;
                end else begin
                    event_code        = bgc_pkg::EV_SHORT;
                    n_awaiting_second = 1'b1;
                    n_window_start    = i_time_ms;
                end
                n_last_event_time = i_time_ms;
                n_is_pressed      = 1'b0;
                n_hold_reported   = 1'b0;
            end
        end else begin
            // long hold while pressed, reported once
            if (r_is_pressed && !r_hold_reported &&
                (held > {16'd0, i_cfg.reset_hold_ms})) begin
                n_hold_reported = 1'b1;
                event_code      = bgc_pkg::EV_RESET_HOLD;
            end
            // press, once the debounce time has passed
            if (!r_is_pressed && (since_last > {16'd0, i_cfg.debounce_ms})) begin
                n_press_start     = i_time_ms;
                n_last_event_time = i_time_ms;
                n_is_pressed      = 1'b1;
            end
        end

        // double-click window expiry is checked last
        if (n_awaiting_second && (since_window > {16'd0, i_cfg.double_click_window_ms})) begin
            n_awaiting_second = 1'b0;
        end
    end

    assign o_event_code = event_code;

    // State update on each processed poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_pressed      <= 1'b0;
            r_last_event_time <= '0;
            r_press_start     <= '0;
            r_window_start    <= '0;
            r_awaiting_second <= 1'b0;
            r_hold_reported   <= 1'b0;
        end else if (i_step) begin
            r_is_pressed      <= n_is_pressed;
            r_last_event_time <= n_last_event_time;
            r_press_start     <= n_press_start;
            r_window_start    <= n_window_start;
            r_awaiting_second <= n_awaiting_second;
            r_hold_reported   <= n_hold_reported;
        end
    end

    // a short press always opens the double-click wait
    a_short_opens_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (event_code == bgc_pkg::EV_SHORT) |=> r_awaiting_second)
        else $error("short press did not open the double-click wait");

    // a double click closes the wait
    a_double_closes_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (event_code == bgc_pkg::EV_DOUBLE) |=> !r_awaiting_second)
        else $error("double click left the wait open");

    // a reset hold is latched and only happens while pressed
    a_hold_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (event_code == bgc_pkg::EV_RESET_HOLD) |=> r_hold_reported && r_is_pressed)
        else $error("reset hold not latched");

    // any release event leaves the button released with the hold flag cleared
    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && ((event_code == bgc_pkg::EV_SHORT) || (event_code == bgc_pkg::EV_LONG) ||
                   (event_code == bgc_pkg::EV_EXTRA) || (event_code == bgc_pkg::EV_DOUBLE))
        |=> !r_is_pressed && !r_hold_reported)
        else $error("release event left the button pressed");

endmodule

@@ src/button_gesture_classifier.sv @@
// Button gesture classifier.
// i_poll carries one poll per request: a millisecond timestamp (time_ms, wraps
// modulo 2^32) and the sampled pin (button_level, 1 = pressed). o_event returns
// exactly one event_code per poll, in order: 0 none, 1 short, 2 long,
// 3 extra long, 4 double click, 5 reset hold.
// The APB port sets the six 16-bit timing windows (ms) at byte addresses
// 0x00..0x14; write only while no poll is in flight. pready is tied high.
// Path: an accepted poll is held in the input register; its event is then
// registered in the result register, from which o_event offers it.
// Throughput: one poll per cycle while o_event.ready is high; the input
// register, the classifier logic and the result register form a two-stage
// pipeline. Stall: while o_event.ready is low a full result register holds,
// the input register still takes one more poll, then i_poll.ready drops.
// Reset (i_rst_n low, synchronous): pipeline emptied, button released, all
// timestamps and flags zero, timing windows back to their defaults.
module button_gesture_classifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bgc_poll_if.sink                            i_poll,
    bgc_event_if.source                         o_event,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bgc_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    bgc_pkg::t_cfg               r_cfg;
    logic [bgc_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic                        cfg_wr;
    logic [bgc_pkg::CFG_W-1:0]   rd_val;

    logic                        r_in_valid;
    logic [bgc_pkg::TIME_W-1:0]  r_in_time;
    logic                        r_in_level;
    logic                        r_out_valid;
    bgc_pkg::t_event             r_out_code;

    logic                        s1_adv;
    logic                        poll_acc;
    bgc_pkg::t_event             core_event;

    // APB register access
    assign pready  = 1'b1;
    assign cfg_idx = paddr[bgc_pkg::CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms            <= bgc_pkg::RST_DEBOUNCE;
            r_cfg.long_press_ms          <= bgc_pkg::RST_LONG_PRESS;
            r_cfg.release_guard_ms       <= bgc_pkg::RST_RELEASE_GUARD;
            r_cfg.double_click_window_ms <= bgc_pkg::RST_DOUBLE_WINDOW;
            r_cfg.extra_long_ms          <= bgc_pkg::RST_EXTRA_LONG;
            r_cfg.reset_hold_ms          <= bgc_pkg::RST_RESET_HOLD;
        end else if (cfg_wr) begin
            case (cfg_idx)
                bgc_pkg::REG_DEBOUNCE:      r_cfg.debounce_ms            <= pwdata[15:0];
                bgc_pkg::REG_LONG_PRESS:    r_cfg.long_press_ms          <= pwdata[15:0];
                bgc_pkg::REG_RELEASE_GUARD: r_cfg.release_guard_ms       <= pwdata[15:0];
                bgc_pkg::REG_DOUBLE_WINDOW: r_cfg.double_click_window_ms <= pwdata[15:0];
                bgc_pkg::REG_EXTRA_LONG:    r_cfg.extra_long_ms          <= pwdata[15:0];
                bgc_pkg::REG_RESET_HOLD:    r_cfg.reset_hold_ms          <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (cfg_idx)
            bgc_pkg::REG_DEBOUNCE:      rd_val = r_cfg.debounce_ms;
            bgc_pkg::REG_LONG_PRESS:    rd_val = r_cfg.long_press_ms;
            bgc_pkg::REG_RELEASE_GUARD: rd_val = r_cfg.release_guard_ms;
            bgc_pkg::REG_DOUBLE_WINDOW: rd_val = r_cfg.double_click_window_ms;
            bgc_pkg::REG_EXTRA_LONG:    rd_val = r_cfg.extra_long_ms;
            bgc_pkg::REG_RESET_HOLD:    rd_val = r_cfg.reset_hold_ms;
            default:                    rd_val = '0;
        endcase
    end
    assign prdata = {16'd0, rd_val};

    // pipeline handshake
    assign s1_adv       = r_in_valid && (!r_out_valid || o_event.ready);
    assign i_poll.ready = !r_in_valid || s1_adv;
    assign poll_acc     = i_poll.valid && i_poll.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (poll_acc) begin
            r_in_valid <= 1'b1;
        end else if (s1_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (poll_acc) begin
            r_in_time  <= i_poll.time_ms;
            r_in_level <= i_poll.button_level;
        end
    end

    bgc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_step         (s1_adv),
        .i_time_ms      (r_in_time),
        .i_button_level (r_in_level),
        .o_event_code   (core_event)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_code <= core_event;
        end
    end

    assign o_event.valid      = r_out_valid;
    assign o_event.event_code = r_out_code;

    // an accepted poll always lands in the input register
    a_poll_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        poll_acc |=> r_in_valid)
        else $error("accepted poll lost");

    // a processed poll always produces a result
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("processed poll produced no result");

    // a full pipeline with a stalled receiver takes no poll
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !o_event.ready |-> !i_poll.ready)
        else $error("poll taken while pipeline is full");

endmodule

@@ sim/tb_button_gesture_classifier.sv @@
`timescale 1ns / 1ps

module tb_button_gesture_classifier;
    import bgc_pkg::*;

    localparam int                   WATCHDOG_LIMIT = 2000;
    localparam int                   PHASE_POLLS    = 105;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED   = 3'd6;

    // Tracks button state and timing windows, predicts one event per poll
    class gesture_scoreboard;
        t_cfg        windows;
        logic        pressed;
        logic        awaiting;
        logic        hold_done;
        logic [31:0] last_evt;
        logic [31:0] press_t;
        logic [31:0] win_t;
        t_event      pending[$];
        int          errors;
        int          tally[6];

        function new();
            windows.debounce_ms            = RST_DEBOUNCE;
            windows.long_press_ms          = RST_LONG_PRESS;
            windows.release_guard_ms       = RST_RELEASE_GUARD;
            windows.double_click_window_ms = RST_DOUBLE_WINDOW;
            windows.extra_long_ms          = RST_EXTRA_LONG;
            windows.reset_hold_ms          = RST_RESET_HOLD;
            pressed   = 1'b0;
            awaiting  = 1'b0;
            hold_done = 1'b0;
            last_evt  = '0;
            press_t   = '0;
            win_t     = '0;
            errors    = 0;
            foreach (tally[i]) tally[i] = 0;
        endfunction

        // Mirror of a register write; only the low 16 bits are kept
        function void set_window(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_DEBOUNCE:      windows.debounce_ms            = value[15:0];
                REG_LONG_PRESS:    windows.long_press_ms          = value[15:0];
                REG_RELEASE_GUARD: windows.release_guard_ms       = value[15:0];
                REG_DOUBLE_WINDOW: windows.double_click_window_ms = value[15:0];
                REG_EXTRA_LONG:    windows.extra_long_ms          = value[15:0];
                REG_RESET_HOLD:    windows.reset_hold_ms          = value[15:0];
                default: ;
            endcase
        endfunction

        // Accepted poll: update state, queue the expected event
        function void note_poll(logic [31:0] now, logic level);
            t_event      ev;
            logic [31:0] quiet;
            logic [31:0] held;
            logic [31:0] waited;
            ev    = EV_NONE;
            quiet = now - last_evt;
            held  = now - press_t;
            if (!level) begin
                if (pressed && quiet > {16'd0, windows.release_guard_ms}) begin
                    if (held > {16'd0, windows.long_press_ms}) begin
                        ev = (held < {16'd0, windows.extra_long_ms}) ? EV_LONG : EV_EXTRA;
                    end else if (awaiting) begin
                        ev       = EV_DOUBLE;
                        awaiting = 1'b0;
                    end else begin
                        ev       = EV_SHORT;
                        awaiting = 1'b1;
                        win_t    = now;
                    end
                    last_evt  = now;
                    pressed   = 1'b0;
                    hold_done = 1'b0;
                end
            end else begin
                if (pressed && !hold_done && held > {16'd0, windows.reset_hold_ms}) begin
                    hold_done = 1'b1;
                    ev        = EV_RESET_HOLD;
                end
                if (!pressed && quiet > {16'd0, windows.debounce_ms}) begin
                    press_t  = now;
                    last_evt = now;
                    pressed  = 1'b1;
                end
            end
            // double-click wait runs out last
            waited = now - win_t;
            if (awaiting && waited > {16'd0, windows.double_click_window_ms}) begin
                awaiting = 1'b0;
            end
            pending.push_back(ev);
            tally[ev]++;
        endfunction

        function void check_event(logic [2:0] code);
            t_event want;
            if (pending.size() == 0) begin
                $error("event_code: no request pending, got %0d", code);
                errors++;
            end else begin
                want = pending.pop_front();
                if (code !== want) begin
                    $error("event_code: expected %0d, got %0d", want, code);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    bgc_poll_if  poll_if ();
    bgc_event_if event_if ();

    gesture_scoreboard sb;
    logic [31:0]       clock_ms;
    int                polls_sent;
    int                stall_cycles;
    int                phases;
    logic              steady;

    button_gesture_classifier u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_poll  (poll_if),
        .o_event (event_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 50 MHz clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Event sink: random back-pressure unless in a steady stretch
    always @(negedge i_clk) begin
        event_if.ready <= steady || ($urandom_range(0, 99) >= 9);
    end

    // Compare every accepted event with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && event_if.valid && event_if.ready) begin
            sb.check_event(event_if.event_code);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((poll_if.valid && poll_if.ready) || (event_if.valid && event_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Value around a timing window: edges, below, above, and rare wild jumps
    function automatic logic [31:0] around(input logic [15:0] w);
        logic [31:0] wide;
        wide = {16'd0, w};
        case ($urandom_range(0, 6))
            0:       around = (w == 16'd0) ? 32'd0 : wide - 32'd1;
            1:       around = wide;
            2:       around = wide + 32'd1;
            3:       around = $urandom_range(0, wide);
            4:       around = wide + $urandom_range(0, wide + 16);
            5:       around = $urandom_range(0, 3);
            default: around = ($urandom_range(0, 7) == 0) ? $urandom() :
                              wide + $urandom_range(2, 40);
        endcase
    endfunction

    // One register write: setup cycle, then access cycle
    task automatic write_window(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_window(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_windows(input logic [31:0] deb, input logic [31:0] lng,
                                 input logic [31:0] grd, input logic [31:0] win,
                                 input logic [31:0] ext, input logic [31:0] rst);
        write_window(REG_DEBOUNCE, deb);
        write_window(REG_LONG_PRESS, lng);
        write_window(REG_RELEASE_GUARD, grd);
        write_window(REG_DOUBLE_WINDOW, win);
        write_window(REG_EXTRA_LONG, ext);
        write_window(REG_RESET_HOLD, rst);
        phases++;
    endtask

    // Send one poll request; called and returning just after a falling edge
    task automatic send_poll(input logic [31:0] now, input logic level);
        while (!steady && $urandom_range(0, 99) < 9) begin
            poll_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        poll_if.valid        <= 1'b1;
        poll_if.time_ms      <= now;
        poll_if.button_level <= level;
        do @(posedge i_clk); while (!poll_if.ready);
        sb.note_poll(now, level);
        polls_sent++;
        @(negedge i_clk);
    endtask

    // Press, a few held polls, release; hold length aimed at a window edge
    task automatic press_hold_release(input logic short_only);
        logic [31:0] press_at;
        logic [31:0] hold;
        logic [31:0] t;
        int          k;
        clock_ms = clock_ms + around(sb.windows.debounce_ms);
        send_poll(clock_ms, 1'b1);
        press_at = clock_ms;
        case (short_only ? 0 : $urandom_range(1, 4))
            0:       hold = $urandom_range(0, 1) ? around(sb.windows.release_guard_ms) :
                            $urandom_range(0, sb.windows.long_press_ms);
            1:       hold = around(sb.windows.long_press_ms);
            2:       hold = around(sb.windows.extra_long_ms);
            3:       hold = around(sb.windows.reset_hold_ms);
            default: hold = around(sb.windows.release_guard_ms);
        endcase
        k = $urandom_range(0, 3);
        repeat (k) begin
            t = press_at + (($urandom_range(0, 2) == 0) ? around(sb.windows.reset_hold_ms) :
                            $urandom_range(0, hold));
            if ((t - press_at) < hold && (t - press_at) >= (clock_ms - press_at)) begin
                clock_ms = t;
                // an occasional bounce low while held
                send_poll(clock_ms, $urandom_range(0, 9) != 0);
            end
        end
        clock_ms = press_at + hold;
        send_poll(clock_ms, 1'b0);
    endtask

    task automatic play_gesture();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: press_hold_release(1'b1);
            2, 3: begin
                press_hold_release(1'b1);
                press_hold_release(1'b1);
            end
            4, 5, 6: press_hold_release(1'b0);
            7: begin
                // noise: random levels, random steps, rare large jumps
                repeat ($urandom_range(1, 4)) begin
                    clock_ms = clock_ms + (($urandom_range(0, 15) == 0) ? $urandom() :
                               $urandom_range(0, 2 * sb.windows.debounce_ms + 4));
                    send_poll(clock_ms, $urandom_range(0, 1));
                end
            end
            8: begin
                // contact bounce right after a press
                clock_ms = clock_ms + around(sb.windows.debounce_ms);
                send_poll(clock_ms, 1'b1);
                repeat ($urandom_range(1, 4)) begin
                    clock_ms = clock_ms + $urandom_range(0, 3);
                    send_poll(clock_ms, $urandom_range(0, 1));
                end
            end
            default: begin
                // released and idle while the double-click wait runs out
                clock_ms = clock_ms + around(sb.windows.double_click_window_ms);
                send_poll(clock_ms, 1'b0);
            end
        endcase
    endtask

    task automatic random_polls(input int count);
        int start;
        start = polls_sent;
        while (polls_sent - start < count) play_gesture();
        poll_if.valid <= 1'b0;
    endtask

    // Wait until every predicted event is back, then let the pipeline empty
    task automatic settle();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Default windows: each gesture, the quiet-time edges and the timestamp wrap
    task automatic directed_polls();
        send_poll(32'd0, 1'b0);
        send_poll(32'd0, 1'b1);          // press inside debounce time
        send_poll(32'd151, 1'b1);        // press accepted
        send_poll(32'd180, 1'b0);        // release inside guard time
        send_poll(32'd300, 1'b0);        // short
        send_poll(32'd451, 1'b1);
        send_poll(32'd540, 1'b0);        // double click
        send_poll(32'd700, 1'b1);
        send_poll(32'd2800, 1'b0);       // long
        send_poll(32'd2950, 1'b1);       // debounce edge, not taken
        send_poll(32'd2951, 1'b1);
        send_poll(32'd22951, 1'b1);      // hold edge, no report yet
        send_poll(32'd22952, 1'b1);      // reset hold
        send_poll(32'd24000, 1'b0);      // extra long
        send_poll(32'd24200, 1'b1);
        send_poll(32'd24300, 1'b0);      // short, wait opens
        send_poll(32'd24551, 1'b1);      // wait expires, press taken
        send_poll(32'd24651, 1'b0);      // short again, not double
        send_poll(32'hFFFF_FF00, 1'b1);
        send_poll(32'h0000_0010, 1'b0);  // short across the wrap
        send_poll(32'd5, 1'b1);          // time going back
        send_poll(32'd6, 1'b0);          // guard
        send_poll(32'hFFFF_FFFF, 1'b1);  // reset hold, huge elapsed
        send_poll(32'hFFFF_FFFF, 1'b0);  // extra long
        clock_ms = 32'hFFFF_FFFF;
    endtask

    initial begin
        sb                   = new();
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        poll_if.valid        = 1'b0;
        poll_if.time_ms      = '0;
        poll_if.button_level = 1'b0;
        event_if.ready       = 1'b1;
        clock_ms             = '0;
        polls_sent           = 0;
        stall_cycles         = 0;
        phases               = 1;
        steady               = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults from reset; a write past the map must change nothing
        write_window(REG_UNMAPPED, 32'h0000_0001);
        directed_polls();
        random_polls(PHASE_POLLS);
        settle();

        // short windows so random steps land on the edges
        apply_windows(32'd3, 32'd20, 32'd2, 32'd15, 32'd40, 32'd60);
        random_polls(PHASE_POLLS);
        settle();

        // all zero, upper bits of the bus set
        apply_windows(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                      32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
        random_polls(PHASE_POLLS);
        settle();

        // all at maximum
        apply_windows(32'h1234_FFFF, 32'h0000_FFFF, 32'h8000_FFFF,
                      32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF);
        random_polls(PHASE_POLLS);
        settle();

        // conflicting windows, with neither side stalling
        steady = 1'b1;
        apply_windows(32'd5, 32'd500, 32'd8, 32'd0, 32'd100, 32'd30);
        random_polls(PHASE_POLLS);
        settle();
        steady = 1'b0;

        // random full-range values
        apply_windows($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        random_polls(PHASE_POLLS);
        settle();

        // random small values
        apply_windows($urandom_range(0, 80), $urandom_range(0, 80), $urandom_range(0, 80),
                      $urandom_range(0, 80), $urandom_range(0, 80), $urandom_range(0, 80));
        random_polls(PHASE_POLLS);

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $error("event_code: %0d expected events never arrived", sb.pending.size());
            sb.errors++;
        end

        $display("Checked %0d polls under %0d window settings", polls_sent, phases);
        $display("Events: short %0d, long %0d, extra long %0d, double %0d, reset hold %0d",
                 sb.tally[EV_SHORT], sb.tally[EV_LONG], sb.tally[EV_EXTRA],
                 sb.tally[EV_DOUBLE], sb.tally[EV_RESET_HOLD]);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
